/* rtl/core/bsfb_pkg.sv */
// -----------------------------------------------------------------------------
// bsfb_pkg
// Shared types and constants of the byte-stuffed frame builder.
// -----------------------------------------------------------------------------
package bsfb_pkg;

   // Line framing bytes.
   localparam logic [7:0] FLAG_BYTE   = 8'h7E;
   localparam logic [7:0] ESCAPE_CODE = 8'h7D;
   localparam logic [7:0] ESC_FLAG    = 8'h5E;
   localparam logic [7:0] ESC_ESC     = 8'h5D;

   // Register reset values.
   localparam logic [7:0] ADDRESS_RESET  = 8'd3;
   localparam logic [7:0] CTRL_ZERO_RESET = 8'd0;
   localparam logic [7:0] CTRL_ONE_RESET  = 8'd64;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ADDRESS   = 2'd0,
      CSR_CTRL_ZERO = 2'd1,
      CSR_CTRL_ONE  = 2'd2
   } csr_index_type;

   // Byte slots of one item, in line order.
   localparam int NUM_SLOTS  = 7;
   localparam int SLOT_IDX_W = 3;
   localparam logic [SLOT_IDX_W-1:0] SLOT_OPEN  = 3'd0;
   localparam logic [SLOT_IDX_W-1:0] SLOT_ADDR  = 3'd1;
   localparam logic [SLOT_IDX_W-1:0] SLOT_CTRL  = 3'd2;
   localparam logic [SLOT_IDX_W-1:0] SLOT_BCC1  = 3'd3;
   localparam logic [SLOT_IDX_W-1:0] SLOT_DATA  = 3'd4;
   localparam logic [SLOT_IDX_W-1:0] SLOT_BCC2  = 3'd5;
   localparam logic [SLOT_IDX_W-1:0] SLOT_CLOSE = 3'd6;

   // Slots whose byte is escaped when it collides with a framing byte.
   localparam logic [NUM_SLOTS-1:0] STUFF_MASK = 7'b0111110;

   // Bytes of one item handed from the header logic to the emitter.
   typedef struct packed {
      logic [NUM_SLOTS-1:0][7:0] bytes;
      logic [NUM_SLOTS-1:0]      valid;
   } slot_bundle_type;

endpackage

/* rtl/core/bsfb_emitter.sv */
// -----------------------------------------------------------------------------
// bsfb_emitter
// Holds the byte slots of one item and sends one word per cycle unless
// stalled, escaping flag and escape bytes, through a registered output stage.
// -----------------------------------------------------------------------------
module bsfb_emitter
   import bsfb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load_valid,
   output logic            load_ready,
   input  slot_bundle_type load_slots,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [7:0]      out_byte,
   output logic            out_run_end,
   output logic            out_frame_end
);

   logic [NUM_SLOTS-1:0][7:0] bytes_ff, bytes_in;
   logic [NUM_SLOTS-1:0]      pend_ff, pend_in;
   logic                      half_ff, half_in;
   logic                      out_valid_ff;
   logic [7:0]                out_byte_ff;
   logic                      out_run_end_ff;
   logic                      out_frame_end_ff;

   logic [SLOT_IDX_W-1:0]     cur;
   logic [7:0]                cur_byte;
   logic                      special;
   logic                      fire;
   logic                      slot_done;
   logic [NUM_SLOTS-1:0]      rest;
   logic [7:0]                word_byte;
   logic                      last_word;

   // Pick the lowest pending slot.
   always_comb begin
      cur = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            cur = SLOT_IDX_W'(i);
         end
      end
   end

   // Form the next line word from the current slot.
   always_comb begin
      cur_byte  = bytes_ff[cur];
      special   = STUFF_MASK[cur] && ((cur_byte == FLAG_BYTE) || (cur_byte == ESCAPE_CODE));
      fire      = (pend_ff != '0) && (!out_valid_ff || out_ready);
      slot_done = !special || half_ff;
      rest      = pend_ff & ~(NUM_SLOTS'(1) << cur);
      last_word = slot_done && (rest == '0);
      if (!special) begin
         word_byte = cur_byte;
      end else if (!half_ff) begin
         word_byte = ESCAPE_CODE;
      end else begin
         word_byte = (cur_byte == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
      end
      load_ready = (pend_ff == '0) || (fire && last_word);
   end

   // Next slot state: retire words, then take a new item.
   always_comb begin
      pend_in  = pend_ff;
      half_in  = half_ff;
      bytes_in = bytes_ff;
      if (fire) begin
         if (slot_done) begin
            pend_in = rest;
            half_in = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end
      if (load_valid && load_ready) begin
         pend_in  = load_slots.valid;
         bytes_in = load_slots.bytes;
         half_in  = 1'b0;
      end
   end

   // Slot control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         half_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         half_ff <= half_in;
      end
   end

   // Slot payload registers.
   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   // Output stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output stage payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         out_byte_ff      <= word_byte;
         out_run_end_ff   <= last_word;
         out_frame_end_ff <= slot_done && (cur == SLOT_CLOSE);
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_byte      = out_byte_ff;
   assign out_run_end   = out_run_end_ff;
   assign out_frame_end = out_frame_end_ff;

endmodule

/* rtl/core/byte_stuffed_frame_builder.sv */
// -----------------------------------------------------------------------------
// byte_stuffed_frame_builder
// Builds stuffed information frames from a stream of payload bytes.
// -----------------------------------------------------------------------------
// Usage:
// The req_ stream carries one payload byte per word; req_tlast marks the
// last byte of a frame and req_tuser carries the sequence bit, which is
// read only on the first byte of a frame. For that first byte the block
// sends the opening flag, address, control and BCC1 ahead of the data;
// for the last byte it adds BCC2 and the closing flag. All bytes between
// the flags are escaped (7E -> 7D 5E, 7D -> 7D 5D).
// The rsp_ stream carries one line byte per word; rsp_tlast marks the
// closing flag and rsp_tuser marks the last word caused by an input word.
// An input word yields 1 to 12 output words, one per cycle while the
// receiver is ready; a mid-frame unescaped byte yields one word, an
// escaped one two. An accepted word is held in the slot buffer, and its
// words then pass the output register. The next input word is taken in the
// cycle the previous one's last output word leaves the slot buffer.
// A stalled receiver holds the output register and then the slot buffer.
// The user writes registers only while idle; the block does not check this.
// The csr_ port is always ready. Reset empties the buffers, closes any open
// frame and restores the register defaults (address 3, control 0 and 64).
// -----------------------------------------------------------------------------
module byte_stuffed_frame_builder
   import bsfb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Input stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] payload_byte
   input  logic                   req_tlast,   // final_payload
   input  logic                   req_tuser,   // [0] seq_bit
   // Output stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] line_byte
   output logic                   rsp_tlast,   // frame_end
   output logic                   rsp_tuser,   // [0] run_end
   // Register write port.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   logic [7:0]      address_ff;
   logic [7:0]      ctrl_zero_ff;
   logic [7:0]      ctrl_one_ff;
   logic            in_frame_ff, in_frame_in;
   logic [7:0]      check_accum_ff, check_accum_in;

   logic            accept;
   logic            load_ready;
   logic [7:0]      ctrl;
   logic [7:0]      bcc2;
   slot_bundle_type slots;

   assign csr_ready  = 1'b1;
   assign req_tready = load_ready;
   assign accept     = req_tvalid && load_ready;

   // Register writes; an index past the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff   <= ADDRESS_RESET;
         ctrl_zero_ff <= CTRL_ZERO_RESET;
         ctrl_one_ff  <= CTRL_ONE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ADDRESS:   address_ff   <= csr_data;
            CSR_CTRL_ZERO: ctrl_zero_ff <= csr_data;
            CSR_CTRL_ONE:  ctrl_one_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Lay out the byte slots of the accepted word and update frame state.
   always_comb begin
      ctrl = req_tuser ? ctrl_one_ff : ctrl_zero_ff;
      bcc2 = (in_frame_ff ? check_accum_ff : 8'h00) ^ req_tdata;

      slots.bytes             = '0;
      slots.bytes[SLOT_OPEN]  = FLAG_BYTE;
      slots.bytes[SLOT_ADDR]  = address_ff;
      slots.bytes[SLOT_CTRL]  = ctrl;
      slots.bytes[SLOT_BCC1]  = address_ff ^ ctrl;
      slots.bytes[SLOT_DATA]  = req_tdata;
      slots.bytes[SLOT_BCC2]  = bcc2;
      slots.bytes[SLOT_CLOSE] = FLAG_BYTE;

      slots.valid             = '0;
      slots.valid[SLOT_OPEN]  = !in_frame_ff;
      slots.valid[SLOT_ADDR]  = !in_frame_ff;
      slots.valid[SLOT_CTRL]  = !in_frame_ff;
      slots.valid[SLOT_BCC1]  = !in_frame_ff;
      slots.valid[SLOT_DATA]  = 1'b1;
      slots.valid[SLOT_BCC2]  = req_tlast;
      slots.valid[SLOT_CLOSE] = req_tlast;

      in_frame_in    = in_frame_ff;
      check_accum_in = check_accum_ff;
      if (accept) begin
         in_frame_in    = !req_tlast;
         check_accum_in = req_tlast ? 8'h00 : bcc2;
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         check_accum_ff <= 8'h00;
      end else begin
         in_frame_ff    <= in_frame_in;
         check_accum_ff <= check_accum_in;
      end
   end

   // Slot buffer and output stage.
   bsfb_emitter u_emitter (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (req_tvalid),
      .load_ready    (load_ready),
      .load_slots    (slots),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_byte      (rsp_tdata),
      .out_run_end   (rsp_tuser),
      .out_frame_end (rsp_tlast)
   );

   // The running check byte is cleared whenever no frame is open.
   a_accum_clear: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (check_accum_ff == 8'h00))
      else $error("check byte not cleared outside a frame");

   // The closing flag ends the run of its input word.
   a_close_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("closing flag is not the last word of its run");

   // The closing word is always the raw flag byte.
   a_close_is_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == FLAG_BYTE))
      else $error("closing word is not a flag");

   // A non-final word leaves a frame open.
   a_frame_opens: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tlast) |=> in_frame_ff)
      else $error("frame not open after a non-final word");

endmodule
